/* rtl/core/text_console_writer_unit_defines.svh */
// ----------------------------------------------------------------------------
// text_console_writer_unit_defines.svh
// Assertion macros shared by the text console writer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define TCW_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define TCW_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and codes of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLS          = 80;
    localparam int ROWS          = 60;
    localparam int CELLS         = COLS * ROWS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);

    // Field widths
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int POS_W    = 13;
    localparam int DATA_W   = 16;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // Character codes and blank cell
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_BLANK   = 8'h07;
    localparam logic [DATA_W-1:0] BLANK_CELL   = {ATTR_BLANK, CH_SPACE};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_SCROLL,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic exec;
        logic sweep_clear;
        logic sweep_scroll;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic                in_valid;
        logic [ACTION_W-1:0] act;
        logic                need_scroll;
        logic                sweep_done;
        logic                out_free;
    } ctrl_sts_t;

endpackage

/* rtl/core/tcw_if.sv */
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channel interfaces: request, response and attribute write.
// ----------------------------------------------------------------------------
interface tcw_req_if;
    logic                            valid;
    logic                            ready;
    logic [tcw_pkg::ACTION_W-1:0]    action;
    logic [tcw_pkg::CHAR_W-1:0]      char_code;
    logic [tcw_pkg::POS_W-1:0]       cell_index;

    modport source (output valid, action, char_code, cell_index, input ready);
    modport sink   (input valid, action, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [tcw_pkg::POS_W-1:0]       cursor_pos;
    logic [tcw_pkg::DATA_W-1:0]      cell_data;

    modport source (output valid, cursor_pos, cell_data, input ready);
    modport sink   (input valid, cursor_pos, cell_data, output ready);
endinterface

interface tcw_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tcw_pkg::ATTR_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell text console with screen store, cursor and scroll.
// ----------------------------------------------------------------------------
// A 80x60 text console. Each request beat on req is one action: put a
// character (newline, backspace and printable bytes), clear the screen, or
// read one cell; each returns exactly one response beat on rsp holding the
// linear cursor position (row*COLS+col) and, for reads, the cell contents.
// Put, read and unused actions are accepted, then executed through the
// single write / registered read port of the screen store. A clear adds
// one pass over the store, then hands the result to the output register.
// A put that scrolls adds one pass in which each cell is copied one row
// up through the same port pair and the bottom row is blanked, followed
// by the same hand-off. After reset the store is cleared by a pass over
// all cells, during which req is not ready; attribute writes on cfg are
// taken at any time but should only be made while the console is idle.
// The response sits in an output register; while rsp is stalled one
// further beat can be accepted and executed, and its result then waits
// until the register is taken, with req not ready in the meantime.
// ----------------------------------------------------------------------------
`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit (
    input  logic        clk,
    input  logic        rst_n,
    tcw_req_if.sink     req,
    tcw_rsp_if.source   rsp,
    tcw_cfg_if.sink     cfg
);

    import tcw_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequencer
    tcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Store, cursor and result registers
    tcw_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // No beat is taken while the store is being swept
    `TCW_ASSERT_IMP(a_no_accept_in_sweep, cmd.in_ready,
        !(cmd.sweep_clear || cmd.sweep_scroll), "request ready during sweep")

    // A result is only loaded when the output register can take it
    `TCW_ASSERT_IMP(a_load_when_free, cmd.load_out, sts.out_free,
        "result loaded over an untaken beat")

    // An accepted beat is executed in the following cycle
    `TCW_ASSERT_NXT(a_accept_then_exec, req.valid && req.ready, cmd.exec,
        "accepted beat not executed")

    // Cursor position stays on screen
    `TCW_ASSERT_IMP(a_pos_range, rsp.valid, rsp.cursor_pos < POS_W'(CELLS),
        "cursor position beyond screen")

endmodule

/* rtl/core/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: item accept, execute, store sweeps and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcw_pkg::ctrl_sts_t    sts,
    output tcw_pkg::ctrl_cmd_t    cmd
);

    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   finish_now;

    // Item completes in the execute cycle unless it needs a sweep or the output register is not free
    assign finish_now = !(sts.act == ACT_CLEAR) &&
                        !((sts.act == ACT_PUT) && sts.need_scroll);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (sts.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.act == ACT_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if ((sts.act == ACT_PUT) && sts.need_scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR,
            ST_SCROLL:
            begin
                if (sts.sweep_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_clear = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec     = 1'b1;
                cmd.load_out = finish_now && sts.out_free;
            end
            ST_CLEAR:
            begin
                cmd.sweep_clear = 1'b1;
            end
            ST_SCROLL:
            begin
                cmd.sweep_scroll = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/core/tcw_dp.sv */
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: item and cursor registers, screen store, sweep counter, result.
// ----------------------------------------------------------------------------
module tcw_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tcw_pkg::ctrl_cmd_t    cmd,
    output tcw_pkg::ctrl_sts_t    sts,
    tcw_req_if.sink               req,
    tcw_rsp_if.source             rsp,
    tcw_cfg_if.sink               cfg
);

    import tcw_pkg::*;

    logic [ATTR_W-1:0]   attr_reg;
    logic [ACTION_W-1:0] act_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic [POS_W-1:0]    idx_reg;

    logic [COL_W-1:0]    col_reg,  col_next;
    logic [ROW_W-1:0]    row_reg,  row_next;
    logic [ADDR_W-1:0]   pos_reg,  pos_next;
    logic [CNT_W-1:0]    cnt_reg,  cnt_next;

    logic [DATA_W-1:0]   res_data_reg;
    logic                rsp_valid_reg;
    logic [POS_W-1:0]    rsp_pos_reg;
    logic [DATA_W-1:0]   rsp_data_reg;

    logic                req_fire;
    logic                is_nl, is_bs, last_col, last_row, col_zero;
    logic                idx_ok, req_idx_ok;
    logic                done_clear, done_scroll;
    logic [CNT_W-1:0]    cnt_dec;
    logic [CNT_W:0]      scr_src;
    logic [DATA_W-1:0]   exec_data;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    assign req.ready = cmd.in_ready;
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;

    // Attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_BLANK;
        end
        else if (cfg.valid)
        begin
            attr_reg <= cfg.data;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            act_reg <= req.action;
            ch_reg  <= req.char_code;
            idx_reg <= req.cell_index;
        end
    end

    // Decode
    assign is_nl      = (ch_reg == CH_NEWLINE);
    assign is_bs      = (ch_reg == CH_BACKSPACE);
    assign last_col   = (col_reg == COL_W'(COLS - 1));
    assign last_row   = (row_reg == ROW_W'(ROWS - 1));
    assign col_zero   = (col_reg == '0);
    assign idx_ok     = ({1'b0, idx_reg} < (POS_W + 1)'(CELLS));
    assign req_idx_ok = ({1'b0, req.cell_index} < (POS_W + 1)'(CELLS));

    // Cursor update
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        pos_next = pos_reg;
        if (cmd.exec)
        begin
            case (act_reg)
                ACT_PUT:
                begin
                    if (is_nl)
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            pos_next = ADDR_W'(LAST_ROW_BASE);
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                            pos_next = pos_reg - ADDR_W'(col_reg) + ADDR_W'(COLS);
                        end
                    end
                    else if (is_bs)
                    begin
                        if (!col_zero)
                        begin
                            col_next = col_reg - 1'b1;
                            pos_next = pos_reg - 1'b1;
                        end
                    end
                    else if (last_col)
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            pos_next = ADDR_W'(LAST_ROW_BASE);
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end
                end
                ACT_CLEAR:
                begin
                    col_next = '0;
                    row_next = '0;
                    pos_next = '0;
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    // Sweep counter: clear ends on the last cell, scroll ends at count CELLS
    assign done_clear  = (cnt_reg == CNT_W'(CELLS - 1));
    assign done_scroll = (cnt_reg == CNT_W'(CELLS));
    assign cnt_dec     = cnt_reg - 1'b1;
    assign scr_src     = {1'b0, cnt_reg} + (CNT_W + 1)'(COLS);

    always_comb
    begin
        cnt_next = cnt_reg;
        if ((cmd.sweep_clear && done_clear) || (cmd.sweep_scroll && done_scroll))
        begin
            cnt_next = '0;
        end
        else if (cmd.sweep_clear || cmd.sweep_scroll)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            pos_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = BLANK_CELL;
        ram_raddr = '0;
        if (cmd.in_ready && req_idx_ok)
        begin
            ram_raddr = req.cell_index[ADDR_W-1:0];
        end
        if (cmd.exec && (act_reg == ACT_PUT))
        begin
            if (is_bs)
            begin
                ram_we    = !col_zero;
                ram_waddr = pos_reg - 1'b1;
            end
            else if (!is_nl)
            begin
                ram_we    = 1'b1;
                ram_wdata = {attr_reg, ch_reg};
            end
        end
        if (cmd.sweep_clear)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[ADDR_W-1:0];
        end
        if (cmd.sweep_scroll)
        begin
            // read one row ahead, write the cell fetched last cycle
            ram_we    = (cnt_reg != '0);
            ram_waddr = cnt_dec[ADDR_W-1:0];
            if (cnt_reg <= CNT_W'(CELLS - COLS))
            begin
                ram_wdata = ram_rdata;
            end
            if (scr_src < (CNT_W + 1)'(CELLS))
            begin
                ram_raddr = scr_src[ADDR_W-1:0];
            end
        end
    end

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result
    assign exec_data = ((act_reg == ACT_READ) && idx_ok) ? ram_rdata : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_data_reg <= exec_data;
        end
        if (cmd.load_out)
        begin
            rsp_pos_reg  <= POS_W'(pos_next);
            rsp_data_reg <= cmd.exec ? exec_data : res_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.cursor_pos = rsp_pos_reg;
    assign rsp.cell_data  = rsp_data_reg;

    assign sts.in_valid    = req.valid;
    assign sts.act         = act_reg;
    assign sts.need_scroll = last_row && (is_nl || (!is_bs && last_col));
    assign sts.sweep_done  = (cmd.sweep_clear && done_clear) ||
                             (cmd.sweep_scroll && done_scroll);
    assign sts.out_free    = !rsp_valid_reg || rsp.ready;

endmodule
